// File: rtl/aes_gcm_engine_defines.svh
// Assertion helpers used by the engine's back end (agcm_back).
`ifndef AES_GCM_ENGINE_DEFINES_SVH
`define AES_GCM_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define AGCM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("aes_gcm_engine: assertion failed");
`define AGCM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("aes_gcm_engine: forbidden condition seen");
`else
`define AGCM_ASSERT(lbl, clk, rst_n, prop)
`define AGCM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/agcm_pkg.sv
`timescale 1ns / 1ps
package agcm_pkg;

	localparam logic [1:0] MODE_IV   = 2'd0;
	localparam logic [1:0] MODE_AAD  = 2'd1;
	localparam logic [1:0] MODE_TEXT = 2'd2;
	localparam logic [1:0] MODE_FIN  = 2'd3;

	localparam logic [1:0] KIND_TEXT   = 2'd0;
	localparam logic [1:0] KIND_TAG    = 2'd1;
	localparam logic [1:0] KIND_VERIFY = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_AUTHFAIL = 2'd1;
	localparam logic [1:0] ST_SEQERR   = 2'd2;

	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_KSIZE = 3'd4;
	localparam logic [2:0] CFG_DIR  = 3'd5;

	localparam logic [4:0] FULL_BYTES = 5'd16;
	localparam logic [4:0] DIRECT_IV_BYTES = 5'd12;
	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_ERR,
		OP_IV_DIRECT,
		OP_IV_HASH,
		OP_AAD,
		OP_TEXT,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t          op;
		logic         fiv;   // close the IV phase before this word
		logic [127:0] data;
		logic [4:0]   n;
	} cmd_t;

	typedef struct packed {
		logic [255:0] key;
		logic [1:0]   key_size;
		logic         direction;
	} cfg_t;

	localparam logic [2047:0] SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(logic [7:0] x);
		return SBOX[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// One AES round without the key add; the final round skips MixColumns.
	function automatic logic [127:0] aes_round(logic [127:0] s, logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = s[127 - 8 * i -: 8];
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 4; w++)
				t[c * 4 + w] = sbox(b[((c + w) % 4) * 4 + w]);
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[c * 4]     = a0 ^ al ^ xtime(a0 ^ a1);
				t[c * 4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[c * 4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[c * 4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
		return r;
	endfunction

	// Eight bits of the GF(2^128) multiply: returns {z, v}.
	function automatic logic [255:0] gf_step8(logic [127:0] z, logic [127:0] v,
			logic [7:0] x8);
		logic [127:0] zz, vv;
		zz = z;
		vv = v;
		for (int i = 0; i < 8; i++) begin
			if (x8[7 - i]) zz = zz ^ vv;
			vv = vv[0] ? ({1'b0, vv[127:1]} ^ {8'he1, 120'b0}) : {1'b0, vv[127:1]};
		end
		return {zz, vv};
	endfunction

	function automatic logic [127:0] byte_mask(logic [4:0] n);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 16; i++)
			if (5'(i) < n) m[127 - 8 * i -: 8] = 8'hff;
		return m;
	endfunction

endpackage

// File: rtl/aes_gcm_engine.sv
`timescale 1ns / 1ps
// A text word passes dispatch, Nr AES rounds (Nr = 10/12/14), 16 GHASH steps and output;
// finish hashes the lengths, then runs Nr AES rounds. AAD and hashed IV words pass dispatch
// and 16 GHASH steps; a word that closes a hashed IV first hashes the IV length. One word is
// worked at a time. After a key write the next word first computes the 4*(Nr+1) key schedule
// words, then the hash subkey in Nr rounds. A two-entry command queue takes words while the
// sequencer works; a one-word result register holds output. arst_n clears control state.
module aes_gcm_engine #(
	parameter int MAX_ROUNDS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [63:0] data_hi,
	input  logic [63:0] data_lo,
	input  logic [4:0]  byte_count,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo,
	output logic [4:0]  out_count,
	output logic [1:0]  out_kind,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	agcm_pkg::cfg_t cfg_q;
	agcm_pkg::cmd_t fe_cmd, q_cmd;
	logic key_change, enq, q_full, q_empty, q_rd;

	// Key and size writes invalidate the schedule; direction does not.
	assign key_change = cfg_we && (cfg_index < agcm_pkg::CFG_DIR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				agcm_pkg::CFG_KEY0:  cfg_q.key[255:192] <= cfg_data;
				agcm_pkg::CFG_KEY1:  cfg_q.key[191:128] <= cfg_data;
				agcm_pkg::CFG_KEY2:  cfg_q.key[127:64]  <= cfg_data;
				agcm_pkg::CFG_KEY3:  cfg_q.key[63:0]    <= cfg_data;
				agcm_pkg::CFG_KSIZE: cfg_q.key_size     <= cfg_data[1:0];
				agcm_pkg::CFG_DIR:   cfg_q.direction    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign full = q_full;

	// Front: classify each word and check segment order.
	agcm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .q_full(q_full), .mode(mode),
		.data_hi(data_hi), .data_lo(data_lo), .byte_count(byte_count),
		.enq(enq), .cmd(fe_cmd)
	);

	// Hold classified words until the sequencer is free.
	agcm_cmd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(enq), .wr_cmd(fe_cmd), .q_full(q_full),
		.rd(q_rd), .q_empty(q_empty), .rd_cmd(q_cmd)
	);

	// Back: key schedule, AES rounds, GHASH and result register.
	agcm_back #(.MAX_ROUNDS(MAX_ROUNDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .rd_cmd(q_cmd), .rd(q_rd),
		.cfg(cfg_q), .key_change(key_change), .pop(pop), .empty(empty),
		.out_hi(out_hi), .out_lo(out_lo), .out_count(out_count), .out_kind(out_kind),
		.status(status)
	);
endmodule

// File: rtl/agcm_cmd_queue.sv
`timescale 1ns / 1ps
module agcm_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  agcm_pkg::cmd_t  wr_cmd,
	output logic            q_full,
	input  logic            rd,
	output logic            q_empty,
	output agcm_pkg::cmd_t  rd_cmd
);
	localparam int DEPTH = agcm_pkg::CMDQ_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	agcm_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_cmd  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end
endmodule

// File: rtl/agcm_front.sv
`timescale 1ns / 1ps
module agcm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            q_full,
	input  logic [1:0]      mode,
	input  logic [63:0]     data_hi,
	input  logic [63:0]     data_lo,
	input  logic [4:0]      byte_count,
	output logic            enq,
	output agcm_pkg::cmd_t  cmd
);
	logic [1:0] phase_q, phase_d;
	logic       closed_q, closed_d;
	logic       iv_seen_q, iv_seen_d;
	logic [4:0] n;
	logic       short;
	logic [127:0] raw;

	assign enq   = push && !q_full;
	assign n     = (byte_count > agcm_pkg::FULL_BYTES) ? agcm_pkg::FULL_BYTES : byte_count;
	assign short = (n != agcm_pkg::FULL_BYTES);
	assign raw   = {data_hi, data_lo};

	// Classify the word and track the segment order.
	always_comb begin
		phase_d   = phase_q;
		closed_d  = closed_q;
		iv_seen_d = iv_seen_q;
		cmd.op    = agcm_pkg::OP_ERR;
		cmd.fiv   = 1'b0;
		cmd.n     = n;
		cmd.data  = raw & agcm_pkg::byte_mask(n);
		case (mode)
			agcm_pkg::MODE_IV: begin
				if (phase_q == 2'd0 && !closed_q) begin
					cmd.op = (!iv_seen_q && n == agcm_pkg::DIRECT_IV_BYTES) ?
						agcm_pkg::OP_IV_DIRECT : agcm_pkg::OP_IV_HASH;
					iv_seen_d = iv_seen_q || (n != 5'd0);
					closed_d  = short;
				end
			end
			agcm_pkg::MODE_AAD: begin
				if (!(phase_q == 2'd2 || (phase_q == 2'd1 && closed_q))) begin
					cmd.op   = agcm_pkg::OP_AAD;
					cmd.fiv  = (phase_q == 2'd0);
					phase_d  = 2'd1;
					closed_d = short;
				end
			end
			agcm_pkg::MODE_TEXT: begin
				if (!(phase_q == 2'd2 && closed_q)) begin
					cmd.op   = agcm_pkg::OP_TEXT;
					cmd.fiv  = (phase_q == 2'd0);
					phase_d  = 2'd2;
					closed_d = short;
				end
			end
			default: begin
				cmd.op    = agcm_pkg::OP_FINISH;
				cmd.fiv   = (phase_q == 2'd0);
				cmd.data  = raw;
				phase_d   = 2'd0;
				closed_d  = 1'b0;
				iv_seen_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			closed_q  <= 1'b0;
			iv_seen_q <= 1'b0;
		end else if (enq) begin
			phase_q   <= phase_d;
			closed_q  <= closed_d;
			iv_seen_q <= iv_seen_d;
		end
	end
endmodule

// File: rtl/agcm_back.sv
`timescale 1ns / 1ps
`include "aes_gcm_engine_defines.svh"
module agcm_back #(
	parameter int MAX_ROUNDS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  agcm_pkg::cmd_t  rd_cmd,
	output logic            rd,
	input  agcm_pkg::cfg_t  cfg,
	input  logic            key_change,
	input  logic            pop,
	output logic            empty,
	output logic [63:0]     out_hi,
	output logic [63:0]     out_lo,
	output logic [4:0]      out_count,
	output logic [1:0]      out_kind,
	output logic [1:0]      status
);
	localparam int RND_W  = $clog2(MAX_ROUNDS + 1);
	localparam int WORD_W = RND_W + 2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_KEY  = 6'b000010,
		ST_AES  = 6'b000100,
		ST_DISP = 6'b001000,
		ST_GH   = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {AD_H, AD_TEXT, AD_FIN} aes_dst_t;
	typedef enum logic [2:0] {GD_ICB, GD_FIV, GD_ACC, GD_TEXT, GD_FIN} gh_dst_t;

	state_t state_q;
	aes_dst_t aes_dst_q;
	gh_dst_t gh_dst_q;

	agcm_pkg::op_t op_q;
	logic fiv_q;
	logic [127:0] blk_q;
	logic [4:0] n_q;

	logic keys_ready_q;
	logic [RND_W-1:0] nr_q, rnd_q;
	logic [3:0] nk_q;
	logic [WORD_W-1:0] wi_q;
	logic [2:0] kj_q;
	logic [7:0] rcon_q;
	logic [31:0] win_q [8];
	logic [127:0] rk_q [MAX_ROUNDS + 1];

	logic [127:0] hsub_q, acc_q, icb_q, rc_q;
	logic [63:0] ivlen_q, aadlen_q, textlen_q;
	logic direct_q;

	logic [127:0] aes_q;
	logic [127:0] gh_z_q, gh_v_q, gh_x_q;
	logic [3:0] gh_cnt_q;

	logic [127:0] pend_data_q;
	logic [4:0] pend_count_q;
	logic [1:0] pend_kind_q, pend_status_q;

	logic out_valid_q;
	logic [127:0] out_data_q;
	logic [4:0] out_count_q;
	logic [1:0] out_kind_q, out_status_q;

	logic [1:0] ksel;
	logic [4:0] nr_full;
	logic [127:0] aes_next, gh_z_next, gh_v_next, tres, fres, rc_inc;
	logic [31:0] kt, kword, win_sel;
	logic [63:0] len_add;
	logic out_load;

	assign ksel    = (cfg.key_size == 2'd3) ? 2'd2 : cfg.key_size;
	assign nr_full = 5'd10 + {2'b0, ksel, 1'b0};
	assign aes_next = agcm_pkg::aes_round(aes_q, rnd_q == nr_q) ^ rk_q[rnd_q];
	assign {gh_z_next, gh_v_next} = agcm_pkg::gf_step8(gh_z_q, gh_v_q, gh_x_q[127:120]);
	assign tres    = (blk_q ^ aes_next) & agcm_pkg::byte_mask(n_q);
	assign fres    = acc_q ^ aes_next;
	assign rc_inc  = {rc_q[127:32], rc_q[31:0] + 32'd1};
	assign len_add = {56'd0, n_q, 3'b000};
	assign rd      = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pop);

	// Next key schedule word.
	always_comb begin
		kt = win_q[7];
		if (kj_q == 3'd0)
			kt = agcm_pkg::sub_word({kt[23:0], kt[31:24]}) ^ {rcon_q, 24'd0};
		else if (nk_q == 4'd8 && kj_q == 3'd4)
			kt = agcm_pkg::sub_word(kt);
		case (nk_q)
			4'd4:    win_sel = win_q[4];
			4'd6:    win_sel = win_q[2];
			default: win_sel = win_q[0];
		endcase
		kword = (wi_q < WORD_W'(nk_q)) ? cfg.key[{~wi_q[2:0], 5'b00000} +: 32] : (win_sel ^ kt);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			rk_q[wi_q[WORD_W-1:2]][{~wi_q[1:0], 5'b00000} +: 32] <= kword;
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i + 1];
			win_q[7] <= kword;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			aes_dst_q <= AD_H;
			gh_dst_q <= GD_ICB;
			op_q <= agcm_pkg::OP_ERR;
			fiv_q <= 1'b0;
			blk_q <= '0;
			n_q <= '0;
			keys_ready_q <= 1'b0;
			nr_q <= '0;
			rnd_q <= '0;
			nk_q <= 4'd4;
			wi_q <= '0;
			kj_q <= '0;
			rcon_q <= 8'h01;
			hsub_q <= '0;
			acc_q <= '0;
			icb_q <= '0;
			rc_q <= '0;
			ivlen_q <= '0;
			aadlen_q <= '0;
			textlen_q <= '0;
			direct_q <= 1'b0;
			aes_q <= '0;
			gh_z_q <= '0;
			gh_v_q <= '0;
			gh_x_q <= '0;
			gh_cnt_q <= '0;
			pend_data_q <= '0;
			pend_count_q <= '0;
			pend_kind_q <= agcm_pkg::KIND_TEXT;
			pend_status_q <= agcm_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_count_q <= '0;
			out_kind_q <= agcm_pkg::KIND_TEXT;
			out_status_q <= agcm_pkg::ST_OK;
		end else begin
			if (key_change) keys_ready_q <= 1'b0;
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						op_q  <= rd_cmd.op;
						fiv_q <= rd_cmd.fiv;
						blk_q <= rd_cmd.data;
						n_q   <= rd_cmd.n;
						if (!keys_ready_q) begin
							nk_q   <= 4'd4 + {1'b0, ksel, 1'b0};
							nr_q   <= (nr_full > 5'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS) :
								RND_W'(nr_full);
							wi_q   <= '0;
							kj_q   <= '0;
							rcon_q <= 8'h01;
							state_q <= ST_KEY;
						end else begin
							state_q <= ST_DISP;
						end
					end
				end
				ST_KEY: begin
					wi_q <= wi_q + 1'b1;
					kj_q <= ({1'b0, kj_q} == nk_q - 4'd1) ? 3'd0 : kj_q + 3'd1;
					if (wi_q >= WORD_W'(nk_q) && kj_q == 3'd0) rcon_q <= agcm_pkg::xtime(rcon_q);
					if (wi_q == {nr_q, 2'b11}) begin
						aes_q     <= rk_q[0];
						rnd_q     <= RND_W'(1);
						aes_dst_q <= AD_H;
						state_q   <= ST_AES;
					end
				end
				ST_AES: begin
					aes_q <= aes_next;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == nr_q) begin
						case (aes_dst_q)
							AD_H: begin
								hsub_q <= aes_next;
								keys_ready_q <= 1'b1;
								state_q <= ST_DISP;
							end
							AD_TEXT: begin
								pend_data_q   <= tres;
								pend_count_q  <= n_q;
								pend_kind_q   <= agcm_pkg::KIND_TEXT;
								pend_status_q <= agcm_pkg::ST_OK;
								gh_z_q   <= '0;
								gh_v_q   <= hsub_q;
								gh_x_q   <= acc_q ^ (cfg.direction ? blk_q : tres);
								gh_cnt_q <= '0;
								gh_dst_q <= GD_TEXT;
								state_q  <= ST_GH;
							end
							default: begin
								if (!cfg.direction) begin
									pend_data_q   <= fres;
									pend_count_q  <= agcm_pkg::FULL_BYTES;
									pend_kind_q   <= agcm_pkg::KIND_TAG;
									pend_status_q <= agcm_pkg::ST_OK;
								end else begin
									pend_data_q   <= '0;
									pend_count_q  <= '0;
									pend_kind_q   <= agcm_pkg::KIND_VERIFY;
									pend_status_q <= (fres != blk_q) ? agcm_pkg::ST_AUTHFAIL :
										agcm_pkg::ST_OK;
								end
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_DISP: begin
					gh_z_q   <= '0;
					gh_v_q   <= hsub_q;
					gh_cnt_q <= '0;
					if (fiv_q) begin
						if (direct_q) begin
							rc_q  <= icb_q;
							fiv_q <= 1'b0;
						end else begin
							gh_x_q   <= icb_q ^ {64'd0, ivlen_q};
							gh_dst_q <= GD_FIV;
							state_q  <= ST_GH;
						end
					end else begin
						case (op_q)
							agcm_pkg::OP_ERR: begin
								pend_data_q   <= '0;
								pend_count_q  <= '0;
								pend_kind_q   <= agcm_pkg::KIND_TEXT;
								pend_status_q <= agcm_pkg::ST_SEQERR;
								state_q <= ST_OUT;
							end
							agcm_pkg::OP_IV_DIRECT: begin
								icb_q    <= {blk_q[127:32], 32'd1};
								direct_q <= 1'b1;
								ivlen_q  <= ivlen_q + len_add;
								state_q  <= ST_IDLE;
							end
							agcm_pkg::OP_IV_HASH: begin
								ivlen_q  <= ivlen_q + len_add;
								gh_x_q   <= icb_q ^ blk_q;
								gh_dst_q <= GD_ICB;
								state_q  <= (n_q != 5'd0) ? ST_GH : ST_IDLE;
							end
							agcm_pkg::OP_AAD: begin
								aadlen_q <= aadlen_q + len_add;
								gh_x_q   <= acc_q ^ blk_q;
								gh_dst_q <= GD_ACC;
								state_q  <= (n_q != 5'd0) ? ST_GH : ST_IDLE;
							end
							agcm_pkg::OP_TEXT: begin
								textlen_q <= textlen_q + len_add;
								if (n_q != 5'd0) begin
									rc_q      <= rc_inc;
									aes_q     <= rc_inc ^ rk_q[0];
									rnd_q     <= RND_W'(1);
									aes_dst_q <= AD_TEXT;
									state_q   <= ST_AES;
								end else begin
									pend_data_q   <= '0;
									pend_count_q  <= '0;
									pend_kind_q   <= agcm_pkg::KIND_TEXT;
									pend_status_q <= agcm_pkg::ST_OK;
									state_q <= ST_OUT;
								end
							end
							agcm_pkg::OP_FINISH: begin
								gh_x_q   <= acc_q ^ {aadlen_q, textlen_q};
								gh_dst_q <= GD_FIN;
								state_q  <= ST_GH;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_GH: begin
					gh_z_q   <= gh_z_next;
					gh_v_q   <= gh_v_next;
					gh_x_q   <= {gh_x_q[119:0], 8'h00};
					gh_cnt_q <= gh_cnt_q + 4'd1;
					if (gh_cnt_q == 4'd15) begin
						case (gh_dst_q)
							GD_ICB: begin
								icb_q   <= gh_z_next;
								state_q <= ST_IDLE;
							end
							GD_FIV: begin
								icb_q   <= gh_z_next;
								rc_q    <= gh_z_next;
								fiv_q   <= 1'b0;
								state_q <= ST_DISP;
							end
							GD_ACC: begin
								acc_q   <= gh_z_next;
								state_q <= ST_IDLE;
							end
							GD_TEXT: begin
								acc_q   <= gh_z_next;
								state_q <= ST_OUT;
							end
							default: begin
								acc_q     <= gh_z_next;
								aes_q     <= icb_q ^ rk_q[0];
								rnd_q     <= RND_W'(1);
								aes_dst_q <= AD_FIN;
								state_q   <= ST_AES;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= pend_data_q;
						out_count_q  <= pend_count_q;
						out_kind_q   <= pend_kind_q;
						out_status_q <= pend_status_q;
						if (op_q == agcm_pkg::OP_FINISH) begin
							acc_q     <= '0;
							icb_q     <= '0;
							rc_q      <= '0;
							ivlen_q   <= '0;
							aadlen_q  <= '0;
							textlen_q <= '0;
							direct_q  <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty     = !out_valid_q;
	assign out_hi    = out_data_q[127:64];
	assign out_lo    = out_data_q[63:0];
	assign out_count = out_count_q;
	assign out_kind  = out_kind_q;
	assign status    = out_status_q;

	// A waiting result is never overwritten or dropped.
	`AGCM_ASSERT(a_out_held, clk, arst_n, (out_valid_q && !pop) |=> (out_valid_q && $stable(out_data_q)))
	// Dispatch only runs with a valid key schedule and hash subkey.
	`AGCM_ASSERT(a_disp_keys, clk, arst_n, (state_q == ST_DISP) |-> keys_ready_q)
	// The round counter stays within the schedule in use.
	`AGCM_ASSERT(a_rnd_range, clk, arst_n, (state_q == ST_AES) |-> (rnd_q != '0 && rnd_q <= nr_q))
	// A command is taken only when the sequencer is free.
	`AGCM_ASSERT_NEVER(a_rd_busy, clk, arst_n, rd && state_q != ST_IDLE)
endmodule
